// ===== hw/rtl/tpom_pkg.sv =====
// Package for the thread-pointer prologue offset matcher: payload types and opcode patterns.
package tpom_pkg;

    // Default longest sequence examined before the scan is forced to end
    localparam int MAX_WORDS_DEFAULT = 32;

    // Position counter width (saturates at its top value)
    localparam int WORD_INDEX_W = 8;

    // Offset accumulator
    localparam int OFFSET_W = 29;
    localparam logic [OFFSET_W-1:0] OFFSET_MAX = 29'h1fff_ffff;

    // stp x29,x30,[sp,#-N]! : imm7 field is don't-care
    localparam logic [31:0] STP_PATTERN = 32'ha980_7bfd;
    localparam logic [31:0] STP_MASK    = ~(32'h0000_007f << 15);

    // mov x29,sp (add x29,sp,#0 with imm12 bits 10..6 free)
    localparam logic [31:0] MOV_PATTERN = 32'h9100_03fd;
    localparam logic [31:0] MOV_MASK    = 32'hffe0_ffff;

    // mrs xN,<thread-pointer register> : Rt is the base register
    localparam logic [31:0] MRS_PATTERN = 32'hd53b_d040;
    localparam logic [31:0] MRS_MASK    = ~32'h0000_001f;

    // ldr x0,[xN]
    localparam logic [31:0] LDR_BASE    = 32'hf940_0000;

    // add xN,xN,#imm12{,lsl #12} : imm12 and shift bit are free
    localparam logic [31:0] ADD_BASE    = 32'h9100_0000;
    localparam logic [31:0] ADD_MASK    = ~32'h007f_fc00;
    localparam int          ADD_SHIFT_BIT = 22;

    // Input transaction
    typedef struct packed {
        logic [31:0] instruction_word;
        logic        last_word;
    } word_t;

    // Output transaction
    typedef struct packed {
        logic                found;
        logic [OFFSET_W-1:0] tls_offset;
    } result_t;

    // Scan phase, one-hot
    typedef enum logic [4:0] {
        PH_FIRST = 5'b00001,
        PH_MOV   = 5'b00010,
        PH_MRS   = 5'b00100,
        PH_SCAN  = 5'b01000,
        PH_DONE  = 5'b10000
    } phase_t;

endpackage

// ===== hw/rtl/tls_prologue_offset_matcher_core.sv =====
// Top level of the thread-pointer prologue offset matcher.
//
//  Channel | Direction | Signals                          | Payload
//  --------+-----------+----------------------------------+-----------------------
//  word    | in        | word_valid / word_ready / word   | instruction_word, last_word
//  result  | out       | result_valid / result_ready / result | found, tls_offset
//
// One transaction per cycle sustained while the result register is not held: a word is
// captured in the input register, examined from it against the registered phase (masks,
// compares and one 30-bit add), and any result is written to the result register.
// A stalled result register holds the input stage; word_ready drops only then.
// rst_n (asynchronous) returns the scan to expect the first word; no clearing pass.
module tls_prologue_offset_matcher_core #(
    parameter int MAX_WORDS = tpom_pkg::MAX_WORDS_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             word_valid,
    output logic             word_ready,
    input  tpom_pkg::word_t  word,
    output logic             result_valid,
    input  logic             result_ready,
    output tpom_pkg::result_t result
);

    localparam logic [tpom_pkg::WORD_INDEX_W-1:0] LAST_POS =
        tpom_pkg::WORD_INDEX_W'(MAX_WORDS - 1);
    localparam logic [tpom_pkg::WORD_INDEX_W-1:0] INDEX_TOP = '1;

    // Input stage
    logic                 in_valid_reg;
    tpom_pkg::word_t      in_data_reg;

    // Scan state
    tpom_pkg::phase_t     phase_reg, phase_next;
    logic [4:0]           base_reg, base_next;
    logic [tpom_pkg::OFFSET_W-1:0] offset_reg, offset_next;
    logic [tpom_pkg::WORD_INDEX_W-1:0] index_reg, index_next;

    // Result stage
    logic                 out_valid_reg;
    tpom_pkg::result_t    out_data_reg;

    logic        advance;
    logic [31:0] w;
    logic        last;
    logic        final_pos;
    logic        is_stp, is_mov, is_mrs, is_ldr, is_add;
    logic [23:0] imm;
    logic [tpom_pkg::OFFSET_W:0] sum_wide;
    logic [tpom_pkg::OFFSET_W-1:0] sum_sat;
    logic        cont;
    logic        success;
    logic        emit;
    tpom_pkg::phase_t exam_phase;
    logic [4:0]  exam_base;
    logic [tpom_pkg::OFFSET_W-1:0] exam_offset;

    // Handshake
    assign advance      = in_valid_reg && (!out_valid_reg || result_ready);
    assign word_ready   = !in_valid_reg || advance;
    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    // Word decode
    assign w    = in_data_reg.instruction_word;
    assign last = in_data_reg.last_word;
    assign final_pos = last || (index_reg >= LAST_POS);

    assign is_stp = (w & tpom_pkg::STP_MASK) == tpom_pkg::STP_PATTERN;
    assign is_mov = (w & tpom_pkg::MOV_MASK) == tpom_pkg::MOV_PATTERN;
    assign is_mrs = (w & tpom_pkg::MRS_MASK) == tpom_pkg::MRS_PATTERN;
    assign is_ldr = w == (tpom_pkg::LDR_BASE | {22'd0, base_reg, 5'd0});
    assign is_add = (w & tpom_pkg::ADD_MASK) ==
                    (tpom_pkg::ADD_BASE | {22'd0, base_reg, 5'd0} | {27'd0, base_reg});

    // Immediate and saturating accumulate
    assign imm      = w[tpom_pkg::ADD_SHIFT_BIT] ? {w[21:10], 12'd0} : {12'd0, w[21:10]};
    assign sum_wide = {1'b0, offset_reg} + {6'd0, imm};
    assign sum_sat  = sum_wide[tpom_pkg::OFFSET_W] ? tpom_pkg::OFFSET_MAX
                                                   : sum_wide[tpom_pkg::OFFSET_W-1:0];

    // Per-phase examination
    always_comb
    begin
        cont        = 1'b0;
        success     = 1'b0;
        exam_phase  = phase_reg;
        exam_base   = base_reg;
        exam_offset = offset_reg;
        unique case (phase_reg)
            tpom_pkg::PH_FIRST:
            begin
                if (is_stp)
                begin
                    cont       = 1'b1;
                    exam_phase = tpom_pkg::PH_MOV;
                end
                else if (is_mrs)
                begin
                    cont       = 1'b1;
                    exam_base  = w[4:0];
                    exam_phase = tpom_pkg::PH_SCAN;
                end
            end
            tpom_pkg::PH_MOV:
            begin
                if (is_mov)
                begin
                    cont       = 1'b1;
                    exam_phase = tpom_pkg::PH_MRS;
                end
            end
            tpom_pkg::PH_MRS:
            begin
                if (is_mrs)
                begin
                    cont       = 1'b1;
                    exam_base  = w[4:0];
                    exam_phase = tpom_pkg::PH_SCAN;
                end
            end
            tpom_pkg::PH_SCAN:
            begin
                if (is_ldr)
                    success = 1'b1;
                else if (is_add)
                begin
                    cont        = 1'b1;
                    exam_offset = sum_sat;
                end
            end
            default:
            begin
                cont = 1'b0;
            end
        endcase
    end

    // A result leaves on success, failure, or continuing at the final position
    assign emit = (phase_reg != tpom_pkg::PH_DONE) && (success || !cont || final_pos);

    // Next scan state
    always_comb
    begin
        phase_next  = phase_reg;
        base_next   = base_reg;
        offset_next = offset_reg;
        index_next  = index_reg;
        if (phase_reg == tpom_pkg::PH_DONE)
        begin
            if (last)
            begin
                phase_next  = tpom_pkg::PH_FIRST;
                base_next   = '0;
                offset_next = '0;
                index_next  = '0;
            end
        end
        else if (emit && last)
        begin
            phase_next  = tpom_pkg::PH_FIRST;
            base_next   = '0;
            offset_next = '0;
            index_next  = '0;
        end
        else
        begin
            phase_next  = emit ? tpom_pkg::PH_DONE : exam_phase;
            base_next   = exam_base;
            offset_next = exam_offset;
            if (index_reg != INDEX_TOP)
                index_next = index_reg + 1'b1;
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (word_ready)
            in_valid_reg <= word_valid;
    end

    always_ff @(posedge clk)
    begin
        if (word_ready && word_valid)
            in_data_reg <= word;
    end

    // Scan state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= tpom_pkg::PH_FIRST;
            base_reg   <= '0;
            offset_reg <= '0;
            index_reg  <= '0;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            base_reg   <= base_next;
            offset_reg <= offset_next;
            index_reg  <= index_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= emit;
        else if (result_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_data_reg.found      <= success;
            out_data_reg.tls_offset <= success ? offset_reg : '0;
        end
    end

`ifndef SYNTHESIS
    // Failure results carry a zero offset
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.found |-> result.tls_offset == '0)
        else $error("failure result with nonzero offset");

    // A held result blocks the input stage
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && !result_ready |-> !word_ready)
        else $error("input stage not stalled behind held result");

    // A result on a non-final word parks the scan
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && emit && !last |=> phase_reg == tpom_pkg::PH_DONE)
        else $error("scan not parked after result");

    // Parked scan gives no further result
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && phase_reg == tpom_pkg::PH_DONE |=> !result_valid || $past(out_valid_reg))
        else $error("result produced while parked");
`endif

endmodule
